// ===== hw/rtl/rsmm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rsmm_pkg;

    localparam int DATA_W    = 32;
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 1;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic [CFG_W-1:0]         t_cfg;
    typedef logic [CFG_IDX_W-1:0]     t_cfg_idx;

    // configuration register indexes
    localparam t_cfg_idx REG_ROWS = 1'b0;
    localparam t_cfg_idx REG_COLS = 1'b1;

    localparam t_data DATA_MAX = 32'sh7fff_ffff;
    localparam t_data DATA_MIN = 32'sh8000_0000;

endpackage

`default_nettype wire

// ===== hw/rtl/rsmm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rsmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rsmm_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none

// one pass over the stored elements, one read a cycle, counting those at most the probe
module rsmm_scan #(
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire rsmm_pkg::t_data    i_probe,
    input  wire logic [CNT_W-1:0]   i_total,
    input  wire rsmm_pkg::t_data    i_rdata,
    output logic                    o_re,
    output logic      [AW-1:0]      o_raddr,
    output logic                    o_done,
    output logic      [CNT_W-1:0]   o_count
);

    import rsmm_pkg::*;

    logic             r_busy;
    logic             r_vld;
    logic             r_last;
    logic             r_done;
    logic [CNT_W-1:0] r_addr;
    logic [CNT_W-1:0] r_count;
    logic             at_end;
    logic             hit;

    assign at_end = (r_addr == i_total - 1'b1);
    assign hit    = (i_rdata <= i_probe);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_vld  <= 1'b0;
            r_last <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_vld  <= r_busy;
            r_last <= r_busy && at_end;
            r_done <= r_vld && r_last;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && at_end) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_addr  <= '0;
            r_count <= '0;
        end else begin
            if (r_busy) begin
                r_addr <= r_addr + 1'b1;
            end
            if (r_vld && hit) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    assign o_re    = r_busy;
    assign o_raddr = r_addr[AW-1:0];
    assign o_done  = r_done;
    assign o_count = r_count;

endmodule

`default_nettype wire

// ===== hw/rtl/row_sorted_matrix_median_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Median of a matrix whose rows are each sorted ascending. Elements are loaded one per
// cycle in row-major order (start high while busy is low); the configuration registers
// set rows (index 0) and columns (index 1), 0 acting as 1 and values above the maximum
// acting as the maximum, and any write restarts loading. After the last element of the
// set, busy stays high while the block binary-searches the value range between the least
// first-of-row and greatest last-of-row element. Each search step is one scan of the
// element memory through a single compare-and-count unit, one read per cycle, and the
// search ends with a final check step. The median is shown on o_median_value for one
// cycle with o_strobe; the receiver cannot stall it, and busy drops in that same cycle,
// ready for the next set.
module row_sorted_matrix_median_top #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire rsmm_pkg::t_data      i_element_value,
    output logic                      o_strobe,
    output rsmm_pkg::t_data           o_median_value,
    input  wire logic                 i_cfg_we,
    input  wire rsmm_pkg::t_cfg_idx   i_cfg_idx,
    input  wire rsmm_pkg::t_cfg       i_cfg_data
);

    import rsmm_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int ROW_W = $clog2(MAX_ROWS + 1);
    localparam int COL_W = $clog2(MAX_COLS + 1);

    localparam logic [1:0] S_LOAD  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;

    logic [1:0]       r_state;
    t_cfg             r_rows_cfg;
    t_cfg             r_cols_cfg;
    logic [AW-1:0]    r_pos;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    t_data            r_least;
    t_data            r_great;
    t_data            r_lo;
    t_data            r_hi;
    t_data            r_mid;
    logic             r_final;
    logic             r_scan_go;
    logic [CNT_W-1:0] r_total;
    logic [CNT_W-1:0] r_k;
    logic             r_strobe;
    t_data            r_median;

    logic [ROW_W-1:0] eff_rows;
    logic [COL_W-1:0] eff_cols;
    logic             accept;
    logic             col_first;
    logic             col_last;
    logic             set_last;
    t_data            n_least;
    t_data            n_great;
    logic             cfg_hit;
    logic signed [DATA_W:0] diff;
    logic signed [DATA_W:0] sum;
    logic signed [DATA_W:0] half;
    logic             more;
    t_data            n_mid;

    logic             scan_re;
    logic [AW-1:0]    scan_raddr;
    logic             scan_done;
    logic [CNT_W-1:0] scan_count;
    t_data            ram_rdata;
    logic             reach_k;

    // effective dimensions
    always_comb begin
        if (r_rows_cfg == '0) begin
            eff_rows = ROW_W'(1);
        end else if (int'(r_rows_cfg) > MAX_ROWS) begin
            eff_rows = ROW_W'(MAX_ROWS);
        end else begin
            eff_rows = ROW_W'(r_rows_cfg);
        end
        if (r_cols_cfg == '0) begin
            eff_cols = COL_W'(1);
        end else if (int'(r_cols_cfg) > MAX_COLS) begin
            eff_cols = COL_W'(MAX_COLS);
        end else begin
            eff_cols = COL_W'(r_cols_cfg);
        end
    end

    assign busy      = (r_state != S_LOAD);
    assign accept    = start && !busy;
    assign col_first = (r_col == '0);
    assign col_last  = (r_col == eff_cols - 1'b1);
    assign set_last  = col_last && (r_row == eff_rows - 1'b1);

    always_comb begin
        n_least = r_least;
        n_great = r_great;
        if (col_first && (i_element_value < r_least)) begin
            n_least = i_element_value;
        end
        if (col_last && (i_element_value > r_great)) begin
            n_great = i_element_value;
        end
    end

    // midpoint truncated toward zero from a 33-bit sum
    always_comb begin
        diff  = {r_hi[DATA_W-1], r_hi} - {r_lo[DATA_W-1], r_lo};
        sum   = {r_hi[DATA_W-1], r_hi} + {r_lo[DATA_W-1], r_lo};
        half  = (sum >>> 1) + {{DATA_W{1'b0}}, (sum[DATA_W] & sum[0])};
        more  = (diff > 33'sd1);
        n_mid = more ? t_data'(half[DATA_W-1:0]) : r_lo;
    end

    assign reach_k = (scan_count >= r_k);
    assign cfg_hit = i_cfg_we;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_rows_cfg <= t_cfg'(1);
            r_cols_cfg <= t_cfg'(1);
            r_pos      <= '0;
            r_row      <= '0;
            r_col      <= '0;
            r_least    <= DATA_MAX;
            r_great    <= DATA_MIN;
            r_scan_go  <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_scan_go <= 1'b0;
            r_strobe  <= 1'b0;
            if (cfg_hit) begin
                unique case (i_cfg_idx)
                    REG_ROWS: r_rows_cfg <= i_cfg_data;
                    REG_COLS: r_cols_cfg <= i_cfg_data;
                endcase
                r_pos   <= '0;
                r_row   <= '0;
                r_col   <= '0;
                r_least <= DATA_MAX;
                r_great <= DATA_MIN;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (accept) begin
                        if (set_last) begin
                            r_state <= S_CHECK;
                        end else begin
                            r_least <= n_least;
                            r_great <= n_great;
                            r_pos   <= r_pos + 1'b1;
                            if (col_last) begin
                                r_col <= '0;
                                r_row <= r_row + 1'b1;
                            end else begin
                                r_col <= r_col + 1'b1;
                            end
                        end
                    end
                end
                S_CHECK: begin
                    r_scan_go <= 1'b1;
                    r_state   <= S_SCAN;
                end
                S_SCAN: begin
                    if (scan_done) begin
                        if (r_final) begin
                            r_strobe <= 1'b1;
                            r_state  <= S_LOAD;
                            r_pos    <= '0;
                            r_row    <= '0;
                            r_col    <= '0;
                            r_least  <= DATA_MAX;
                            r_great  <= DATA_MIN;
                        end else begin
                            r_state <= S_CHECK;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    // search bounds and result
    always_ff @(posedge i_clk) begin
        r_total <= CNT_W'(eff_rows) * CNT_W'(eff_cols);
        r_k     <= CNT_W'((r_total + 1'b1) >> 1);
        if (accept && set_last) begin
            r_lo <= n_least;
            r_hi <= n_great;
        end
        if (r_state == S_CHECK) begin
            r_mid   <= n_mid;
            r_final <= !more;
        end
        if ((r_state == S_SCAN) && scan_done) begin
            if (r_final) begin
                r_median <= reach_k ? r_lo : r_hi;
            end else if (reach_k) begin
                r_hi <= r_mid;
            end else begin
                r_lo <= r_mid + 1'b1;
            end
        end
    end

    rsmm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_pos),
        .i_wdata (i_element_value),
        .i_re    (scan_re),
        .i_raddr (scan_raddr),
        .o_rdata (ram_rdata)
    );

    rsmm_scan #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CNT_W (CNT_W)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_scan_go),
        .i_probe (r_mid),
        .i_total (r_total),
        .i_rdata (ram_rdata),
        .o_re    (scan_re),
        .o_raddr (scan_raddr),
        .o_done  (scan_done),
        .o_count (scan_count)
    );

    assign o_strobe       = r_strobe;
    assign o_median_value = r_median;

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result shown while still busy");

    a_done_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_done |-> (r_state == S_SCAN))
        else $error("scan finished outside a search step");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_done |-> (scan_count <= r_total))
        else $error("count exceeds number of stored elements");

    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(accept))
        else $error("search started without a last item");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import rsmm_pkg::*;

    localparam int          MAX_ROWS      = 32;
    localparam int          MAX_COLS      = 32;
    localparam int          STORE_DEPTH   = MAX_ROWS * MAX_COLS;
    localparam int unsigned RANDOM_ITEMS  = 1800;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned DRAIN_CYCLES  = 50;
    localparam int unsigned CYCLE_LIMIT   = 2_000_000;
    localparam int          DIRECTED_LEN  = 25;

    typedef enum logic {STEP_CFG, STEP_ELEM} t_step_kind;

    typedef struct packed {
        t_step_kind kind;
        t_cfg_idx   idx;
        t_cfg       cfg;
        t_data      value;
        logic       typed;
        t_data      median;
    } t_step;

    localparam t_step DIRECTED_STEPS [DIRECTED_LEN] = '{
        '{STEP_ELEM, REG_ROWS, 6'd0, DATA_MAX, 1'b1, DATA_MAX},
        '{STEP_ELEM, REG_ROWS, 6'd0, DATA_MIN, 1'b1, DATA_MIN},
        '{STEP_ELEM, REG_ROWS, 6'd0, 0,        1'b1, 0},
        '{STEP_CFG,  REG_ROWS, 6'd0, 0,        1'b0, 0},
        '{STEP_CFG,  REG_COLS, 6'd3, 0,        1'b0, 0},
        '{STEP_ELEM, REG_ROWS, 6'd0, -5,       1'b0, 0},
        '{STEP_ELEM, REG_ROWS, 6'd0, 7,        1'b0, 0},
        '{STEP_ELEM, REG_ROWS, 6'd0, 9,        1'b1, 7},
        // row out of order
        '{STEP_ELEM, REG_ROWS, 6'd0, 9,        1'b0, 0},
        '{STEP_ELEM, REG_ROWS, 6'd0, -3,       1'b0, 0},
        '{STEP_ELEM, REG_ROWS, 6'd0, 4,        1'b0, 0},
        // even element count
        '{STEP_CFG,  REG_ROWS, 6'd2, 0,        1'b0, 0},
        '{STEP_CFG,  REG_COLS, 6'd2, 0,        1'b0, 0},
        '{STEP_ELEM, REG_ROWS, 6'd0, 1,        1'b0, 0},
        '{STEP_ELEM, REG_ROWS, 6'd0, 4,        1'b0, 0},
        '{STEP_ELEM, REG_ROWS, 6'd0, 2,        1'b0, 0},
        '{STEP_ELEM, REG_ROWS, 6'd0, 3,        1'b1, 2},
        // full value range, mid needs the wide sum
        '{STEP_CFG,  REG_ROWS, 6'd1, 0,        1'b0, 0},
        '{STEP_ELEM, REG_ROWS, 6'd0, DATA_MIN, 1'b0, 0},
        '{STEP_ELEM, REG_ROWS, 6'd0, DATA_MAX, 1'b1, DATA_MIN},
        '{STEP_ELEM, REG_ROWS, 6'd0, DATA_MAX, 1'b0, 0},
        '{STEP_ELEM, REG_ROWS, 6'd0, DATA_MAX, 1'b1, DATA_MAX},
        // half a set, then a write throws it away
        '{STEP_ELEM, REG_ROWS, 6'd0, 11,       1'b0, 0},
        '{STEP_CFG,  REG_COLS, 6'd1, 0,        1'b0, 0},
        '{STEP_ELEM, REG_ROWS, 6'd0, 42,       1'b1, 42}
    };

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_data    i_element_value;
    logic     o_strobe;
    t_data    o_median_value;
    logic     i_cfg_we;
    t_cfg_idx i_cfg_idx;
    t_cfg     i_cfg_data;

    // shadow of the block
    t_data       element_copy [STORE_DEPTH];
    t_cfg        rows_reg;
    t_cfg        cols_reg;
    int unsigned load_pos;
    t_data       row_first_min;
    t_data       row_last_max;

    t_data       pending_medians [$];
    t_data       median_want;
    int unsigned mismatch_count;
    int unsigned cycle_count;
    int unsigned elements_loaded;

    row_sorted_matrix_median_top #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_element_value(i_element_value),
        .o_strobe       (o_strobe),
        .o_median_value (o_median_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int unsigned dim_eff(t_cfg v, int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic void restart_load();
        load_pos      = 0;
        row_first_min = DATA_MAX;
        row_last_max  = DATA_MIN;
    endfunction

    function automatic int unsigned count_at_most(longint bound, int unsigned total);
        int unsigned n;
        n = 0;
        for (int unsigned i = 0; i < total; i++) begin
            if (longint'(element_copy[i]) <= bound) n++;
        end
        return n;
    endfunction

    // stores one element; returns 1 with the median when it completes the set
    function automatic bit load_element(input t_data value, output t_data median);
        int unsigned rows;
        int unsigned cols;
        int unsigned total;
        int unsigned k;
        int unsigned pos;
        int unsigned col;
        longint      lo;
        longint      hi;
        longint      mid;
        median = '0;
        rows   = dim_eff(rows_reg, MAX_ROWS);
        cols   = dim_eff(cols_reg, MAX_COLS);
        total  = rows * cols;
        k      = (total + 1) / 2;
        pos    = load_pos;
        if (pos >= STORE_DEPTH) pos = STORE_DEPTH - 1;
        element_copy[pos] = value;
        col = pos % cols;
        if (col == 0 && value < row_first_min) row_first_min = value;
        if (col == cols - 1 && value > row_last_max) row_last_max = value;
        if (pos + 1 < total) begin
            load_pos = pos + 1;
            return 1'b0;
        end
        lo = row_first_min;
        hi = row_last_max;
        while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (count_at_most(mid, total) >= k) hi = mid;
            else lo = mid + 1;
        end
        median = (count_at_most(lo, total) >= k) ? t_data'(lo) : t_data'(hi);
        restart_load();
        return 1'b1;
    endfunction

    function automatic int unsigned pick_gap(bit gaps_on);
        int unsigned r;
        if (!gaps_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic longint row_start_value(int unsigned style);
        if (style < 4) return longint'(t_data'($urandom())) >>> $urandom_range(0, 31);
        if (style < 7) return longint'($urandom_range(0, 8)) - 4;
        if (style < 9) return longint'($urandom_range(0, 2000)) - 1000;
        case ($urandom_range(0, 2))
            0:       return DATA_MIN;
            1:       return -1;
            default: return 0;
        endcase
    endfunction

    function automatic longint row_step_value(int unsigned style);
        if (style < 4) return longint'($urandom() >> $urandom_range(3, 31));
        if (style < 7) return $urandom_range(0, 2);
        if (style < 9) return $urandom_range(0, 100);
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 1;
            default: return longint'(32'h8000_0000);
        endcase
    endfunction

    task automatic send_element(input t_data value, input int unsigned gap,
                                input bit typed, input t_data typed_median);
        t_data median;
        bit    produced;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_element_value <= value;
        do @(posedge i_clk); while (busy !== 1'b0);
        produced = load_element(value, median);
        elements_loaded++;
        if (typed) pending_medians.push_back(typed_median);
        else if (produced) pending_medians.push_back(median);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_cfg data);
        start <= 1'b0;
        while (pending_medians.size() != 0) @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        // a half-loaded set leaves nothing to wait on, so let it settle first
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_ROWS) rows_reg = data;
        else cols_reg = data;
        restart_load();
    endtask

    task automatic load_set(input int unsigned n_items, input int unsigned cols,
                            input bit gaps_on);
        int unsigned style;
        bit          unsorted;
        longint      cur;
        style    = $urandom_range(0, 9);
        unsorted = ($urandom_range(0, 6) == 0);
        cur      = 0;
        for (int unsigned i = 0; i < n_items; i++) begin
            if (unsorted || i % cols == 0) begin
                cur = row_start_value(style);
            end else begin
                cur = cur + row_step_value(style);
                if (cur > DATA_MAX) cur = DATA_MAX;
            end
            send_element(t_data'(cur), pick_gap(gaps_on), 1'b0, '0);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pending_medians.size() == 0) begin
                $display("%0t: median %0d with none expected", $time, o_median_value);
                mismatch_count++;
            end else begin
                median_want = pending_medians.pop_front();
                if (o_median_value !== median_want) begin
                    $display("%0t: median mismatch: expected %0d, got %0d",
                             $time, median_want, o_median_value);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        t_cfg        rows_pick;
        t_cfg        cols_pick;
        t_cfg        big_dim;
        t_cfg        small_dim;
        int unsigned total;
        int unsigned cols;
        int unsigned n_sets;
        int unsigned phase;
        bit          gaps_on;

        mismatch_count  = 0;
        cycle_count     = 0;
        elements_loaded = 0;
        rows_reg        = t_cfg'(1);
        cols_reg        = t_cfg'(1);
        restart_load();

        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_element_value <= '0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= REG_ROWS;
        i_cfg_data      <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIRECTED_LEN; i++) begin
            if (DIRECTED_STEPS[i].kind == STEP_CFG) begin
                write_reg(DIRECTED_STEPS[i].idx, DIRECTED_STEPS[i].cfg);
            end else begin
                send_element(DIRECTED_STEPS[i].value, pick_gap(1'b1),
                             DIRECTED_STEPS[i].typed, DIRECTED_STEPS[i].median);
            end
        end

        elements_loaded = 0;
        phase           = 0;
        while (elements_loaded < RANDOM_ITEMS) begin
            // one full-size set early; otherwise mostly small matrices
            if (phase == 2) begin
                rows_pick = 6'd63;
                cols_pick = 6'd63;
            end else if (phase == 1 || $urandom_range(0, 99) < 15) begin
                big_dim   = t_cfg'($urandom_range(32, 63));
                small_dim = t_cfg'($urandom_range(0, 2));
                if ($urandom_range(0, 1)) begin
                    rows_pick = big_dim;
                    cols_pick = small_dim;
                end else begin
                    rows_pick = small_dim;
                    cols_pick = big_dim;
                end
            end else begin
                rows_pick = t_cfg'($urandom_range(0, 6));
                cols_pick = t_cfg'($urandom_range(0, 6));
            end
            if ($urandom_range(0, 1)) begin
                write_reg(REG_ROWS, rows_pick);
                write_reg(REG_COLS, cols_pick);
            end else begin
                write_reg(REG_COLS, cols_pick);
                write_reg(REG_ROWS, rows_pick);
            end

            cols    = dim_eff(cols_pick, MAX_COLS);
            total   = dim_eff(rows_pick, MAX_ROWS) * cols;
            gaps_on = ($urandom_range(0, 3) != 0);
            n_sets  = (total > 64) ? 1 : $urandom_range(1, 4);
            repeat (n_sets) load_set(total, cols, gaps_on);
            if (total > 1 && $urandom_range(0, 4) == 0) begin
                load_set($urandom_range(1, total - 1), cols, gaps_on);
            end
            phase++;
        end

        start <= 1'b0;
        while (pending_medians.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
